### design/dtlv_pkg.sv
`default_nettype none

package dtlv_pkg;

  // Option codes of the DHCP options area.
  localparam logic [7:0] CODE_HOSTNAME   = 8'h0C;
  localparam logic [7:0] CODE_REQ_IP     = 8'h32;
  localparam logic [7:0] CODE_LEASE      = 8'h33;
  localparam logic [7:0] CODE_MSG_TYPE   = 8'h35;
  localparam logic [7:0] CODE_SERVER     = 8'h36;
  localparam logic [7:0] CODE_PARAM_LIST = 8'h37;
  localparam logic [7:0] CODE_END        = 8'hFF;

  // Lease time reported when no lease option was seen.
  localparam logic [31:0] LEASE_DEFAULT = 32'h0000_FFFF;

  // Default depth of the queue between the classifier and the parser.
  localparam int unsigned FIFO_DEPTH = 2;

  // Number of value bytes captured into the 32-bit accumulator.
  localparam logic [2:0] CAPTURE_BYTES = 3'd4;

  // Class of a byte, as seen when it is taken as an option code.
  typedef enum logic [2:0] {
    CLS_NAME,
    CLS_REQ_IP,
    CLS_LEASE,
    CLS_MSG,
    CLS_SERVER,
    CLS_LIST,
    CLS_END,
    CLS_OTHER
  } dtlv_cls_e;

  // Parse phase of the options area.
  typedef enum logic [1:0] {
    PH_CODE,
    PH_LEN,
    PH_VALUE
  } dtlv_phase_e;

  // Reported parse status.
  typedef enum logic [1:0] {
    ST_OK,
    ST_OVERFLOW,
    ST_UNDEF
  } dtlv_status_e;

  // One classified byte travelling from the front end to the parser.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    dtlv_cls_e  cls;
  } dtlv_item_t;

  // Map a byte to its option class.
  function automatic dtlv_cls_e classify(input logic [7:0] code);
    dtlv_cls_e cls;
    unique case (code)
      CODE_HOSTNAME:   cls = CLS_NAME;
      CODE_REQ_IP:     cls = CLS_REQ_IP;
      CODE_LEASE:      cls = CLS_LEASE;
      CODE_MSG_TYPE:   cls = CLS_MSG;
      CODE_SERVER:     cls = CLS_SERVER;
      CODE_PARAM_LIST: cls = CLS_LIST;
      CODE_END:        cls = CLS_END;
      default:         cls = CLS_OTHER;
    endcase
    return cls;
  endfunction

endpackage

`default_nettype wire

### design/dhcp_option_tlv_parser.sv
`default_nettype none

// DHCP options parser: takes the options area one byte per transaction and
// returns one result per byte, echoing the byte, flagging host-name and
// parameter-list value bytes, and reporting the message type, requested IP,
// lease time and server identifier captured so far, with done and status.
// It sustains one byte per clock cycle when the output is not stalled; each byte
// is first written into the front-end queue and then, when the output register is
// free or being drained, moves into the output register, where its result is presented.
// The combinational parse step in the back end sets that rate, and
// the queue of FifoDepth entries lets input and output stall independently.

module dhcp_option_tlv_parser #(
  parameter int unsigned FifoDepth = dtlv_pkg::FIFO_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  option_byte_i,
  input  wire logic        first_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       data_byte_o,
  output logic             name_byte_valid_o,
  output logic             list_byte_valid_o,
  output logic             done_res_o,
  output logic [1:0]       status_o,
  output logic [7:0]       message_type_o,
  output logic [31:0]      requested_ip_o,
  output logic [31:0]      lease_time_o,
  output logic [31:0]      server_ip_o
);

  dtlv_pkg::dtlv_item_t wr_item, rd_item;
  logic push, pop, full, empty;

  // Front end: accepts and classifies bytes.
  dtlv_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .option_byte_i (option_byte_i),
    .first_i       (first_i),
    .last_i        (last_i),
    .full_i        (full),
    .push_o        (push),
    .item_o        (wr_item)
  );

  // Queue between front end and parser.
  dtlv_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_item_i (wr_item),
    .pop_i     (pop),
    .rd_item_o (rd_item),
    .full_o    (full),
    .empty_o   (empty)
  );

  // Back end: option parser and output register.
  dtlv_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (empty),
    .item_i            (rd_item),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .data_byte_o       (data_byte_o),
    .name_byte_valid_o (name_byte_valid_o),
    .list_byte_valid_o (list_byte_valid_o),
    .done_res_o        (done_res_o),
    .status_o          (status_o),
    .message_type_o    (message_type_o),
    .requested_ip_o    (requested_ip_o),
    .lease_time_o      (lease_time_o),
    .server_ip_o       (server_ip_o)
  );

  // Any error status means the parse has finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != dtlv_pkg::ST_OK) |-> done_res_o)
    else $error("error status reported without done");

  // A value byte belongs to one option only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(name_byte_valid_o && list_byte_valid_o))
    else $error("byte flagged as both host name and parameter list");

  // A new result can only come from an item that was waiting in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!empty))
    else $error("result produced from an empty queue");

  // The queue never takes a transaction while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push)
    else $error("push into a full queue");

endmodule

`default_nettype wire

### design/dtlv_front.sv
`default_nettype none

module dtlv_front (
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         option_byte_i,
  input  wire logic               first_i,
  input  wire logic               last_i,
  input  wire logic               full_i,
  output logic                    push_o,
  output dtlv_pkg::dtlv_item_t    item_o
);

  // Accept a transaction whenever the queue has room.
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Classify the byte so the parser only has to look at a small code.
  always_comb begin
    item_o.data  = option_byte_i;
    item_o.first = first_i;
    item_o.last  = last_i;
    item_o.cls   = dtlv_pkg::classify(option_byte_i);
  end

endmodule

`default_nettype wire

### design/dtlv_fifo.sv
`default_nettype none

module dtlv_fifo #(
  parameter int unsigned Depth = dtlv_pkg::FIFO_DEPTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire dtlv_pkg::dtlv_item_t wr_item_i,
  input  wire logic                 pop_i,
  output dtlv_pkg::dtlv_item_t      rd_item_o,
  output logic                      full_o,
  output logic                      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dtlv_pkg::dtlv_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign rd_item_o = mem_q[rd_ptr_q];

  // Storage for queued items.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### design/dtlv_back.sv
`default_nettype none

module dtlv_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 empty_i,
  input  wire dtlv_pkg::dtlv_item_t item_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [7:0]                data_byte_o,
  output logic                      name_byte_valid_o,
  output logic                      list_byte_valid_o,
  output logic                      done_res_o,
  output logic [1:0]                status_o,
  output logic [7:0]                message_type_o,
  output logic [31:0]               requested_ip_o,
  output logic [31:0]               lease_time_o,
  output logic [31:0]               server_ip_o
);

  dtlv_pkg::dtlv_phase_e  phase_q, phase_d;
  dtlv_pkg::dtlv_cls_e    cls_q, cls_d;
  dtlv_pkg::dtlv_status_e err_q, err_d;
  logic [7:0]  left_q, left_d;
  logic [2:0]  idx_q, idx_d;
  logic [31:0] shift_q, shift_d;
  logic [7:0]  msg_q, msg_d;
  logic [31:0] req_q, req_d;
  logic [31:0] lease_q, lease_d;
  logic [31:0] server_q, server_d;
  logic        fin_q, fin_d;
  logic        name_v, list_v, commit;
  logic        out_valid_q;
  logic [7:0]  data_q;
  logic        name_q, list_q;

  // Take the next item when the output register is free or being drained.
  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  // Parse step for the item at the head of the queue.
  always_comb begin
    phase_d  = phase_q;
    cls_d    = cls_q;
    err_d    = err_q;
    left_d   = left_q;
    idx_d    = idx_q;
    shift_d  = shift_q;
    msg_d    = msg_q;
    req_d    = req_q;
    lease_d  = lease_q;
    server_d = server_q;
    fin_d    = fin_q;
    name_v   = 1'b0;
    list_v   = 1'b0;
    commit   = 1'b0;

    // A first byte starts a new area from a clean slate.
    if (item_i.first) begin
      phase_d  = dtlv_pkg::PH_CODE;
      cls_d    = dtlv_pkg::CLS_OTHER;
      err_d    = dtlv_pkg::ST_OK;
      left_d   = '0;
      idx_d    = '0;
      shift_d  = '0;
      msg_d    = '0;
      req_d    = '0;
      lease_d  = dtlv_pkg::LEASE_DEFAULT;
      server_d = '0;
      fin_d    = 1'b0;
    end

    if (!fin_d) begin
      unique case (phase_d)
        dtlv_pkg::PH_LEN: begin
          left_d  = item_i.data;
          idx_d   = '0;
          shift_d = '0;
          if (item_i.data == 8'd0) begin
            commit = 1'b1;
          end else if (item_i.last) begin
            err_d = dtlv_pkg::ST_OVERFLOW;
            fin_d = 1'b1;
          end else begin
            phase_d = dtlv_pkg::PH_VALUE;
          end
        end
        dtlv_pkg::PH_VALUE: begin
          name_v = (cls_d == dtlv_pkg::CLS_NAME);
          list_v = (cls_d == dtlv_pkg::CLS_LIST);
          // Big-endian capture of the first four value bytes.
          if (idx_d < dtlv_pkg::CAPTURE_BYTES) begin
            case (idx_d[1:0])
              2'd0:    shift_d[31:24] = item_i.data;
              2'd1:    shift_d[23:16] = item_i.data;
              2'd2:    shift_d[15:8]  = item_i.data;
              default: shift_d[7:0]   = item_i.data;
            endcase
            idx_d = idx_d + 3'd1;
          end
          left_d = left_d - 8'd1;
          if (left_d == 8'd0) begin
            commit = 1'b1;
          end else if (item_i.last) begin
            err_d = dtlv_pkg::ST_OVERFLOW;
            fin_d = 1'b1;
          end
        end
        default: begin
          if (item_i.cls == dtlv_pkg::CLS_END) begin
            fin_d = 1'b1;
          end else if (item_i.last) begin
            err_d = dtlv_pkg::ST_OVERFLOW;
            fin_d = 1'b1;
          end else begin
            cls_d   = item_i.cls;
            phase_d = dtlv_pkg::PH_LEN;
          end
        end
      endcase

      // A complete option commits its capture or flags an undefined code.
      if (commit) begin
        if (cls_d == dtlv_pkg::CLS_OTHER || cls_d == dtlv_pkg::CLS_END) begin
          err_d = dtlv_pkg::ST_UNDEF;
          fin_d = 1'b1;
        end else begin
          case (cls_d)
            dtlv_pkg::CLS_REQ_IP: req_d    = shift_d;
            dtlv_pkg::CLS_LEASE:  lease_d  = shift_d;
            dtlv_pkg::CLS_MSG:    msg_d    = shift_d[31:24];
            dtlv_pkg::CLS_SERVER: server_d = shift_d;
            default:              ;
          endcase
          phase_d = dtlv_pkg::PH_CODE;
          if (item_i.last) begin
            fin_d = 1'b1;
          end
        end
      end
    end
  end

  // Parse state and captured results, updated once per popped item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= dtlv_pkg::PH_CODE;
      cls_q    <= dtlv_pkg::CLS_OTHER;
      err_q    <= dtlv_pkg::ST_OK;
      left_q   <= '0;
      idx_q    <= '0;
      shift_q  <= '0;
      msg_q    <= '0;
      req_q    <= '0;
      lease_q  <= dtlv_pkg::LEASE_DEFAULT;
      server_q <= '0;
      fin_q    <= 1'b0;
    end else if (pop_o) begin
      phase_q  <= phase_d;
      cls_q    <= cls_d;
      err_q    <= err_d;
      left_q   <= left_d;
      idx_q    <= idx_d;
      shift_q  <= shift_d;
      msg_q    <= msg_d;
      req_q    <= req_d;
      lease_q  <= lease_d;
      server_q <= server_d;
      fin_q    <= fin_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Per-byte result fields.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= item_i.data;
      name_q <= name_v;
      list_q <= list_v;
    end
  end

  // Captured results change only on a pop, together with the output register.
  assign out_valid_o       = out_valid_q;
  assign data_byte_o       = data_q;
  assign name_byte_valid_o = name_q;
  assign list_byte_valid_o = list_q;
  assign done_res_o        = fin_q;
  assign status_o          = err_q;
  assign message_type_o    = msg_q;
  assign requested_ip_o    = req_q;
  assign lease_time_o      = lease_q;
  assign server_ip_o       = server_q;

endmodule

`default_nettype wire
